// File: rtl/kmh_pkg.sv
// Shared types, constants and the entry ordering function for the k-way merge heap.
// Depends on nothing; imported by kway_merge_heap_top.
package kmh_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int DEF_RUNS     = 16;

  localparam int KEY_W    = 64;
  localparam int TAG_W    = 4;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 72;

  // Operation codes carried on the input side band.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Heap order: smaller key first, equal keys by lower run tag.
  function automatic logic entry_before(entry_t a, entry_t b);
    logic lt;
    if (a.key != b.key) begin
      lt = (a.key < b.key);
    end else begin
      lt = (a.tag < b.tag);
    end
    return lt;
  endfunction

endpackage

// File: rtl/kway_merge_heap_top.sv
// Throughput: one word at a time; s_tready is high only while the sequencer is idle.
// This follows from the single heap memory and the one shared entry comparator.
// Reset (rst, synchronous, active high) empties the heap and clears all run counts at once.
// Heap storage holds no reset value and needs no clearing pass; only filled slots are used.
//
// Merge core of an external merge sort. A min-heap of (key, run tag) entries lives in one
// simple dual-port memory (one write, one registered read per cycle). A small sequencer walks
// the heap with a hole: the moving entry is held in a register and only written once it settles,
// while displaced entries are shifted into the hole one level per step. Every ordering decision
// goes through one shared comparator whose operands are selected by the sequencer state.
// Depends on kmh_pkg.
module kway_merge_heap_top
  import kmh_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int RUNS     = DEF_RUNS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,   // value[63:0], run[67:64], zero pad[71:68]
  input  logic                s_tuser,   // operation: 0 insert, 1 pop
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata,   // out_value[63:0], out_run[67:64], run_drained[68],
                                         // heap_empty[69], zero pad[71:70]
  output logic [STATUS_W-1:0] m_tuser    // status: 0 ok, 1 pop on empty, 2 insert on full
);

  localparam int AW        = $clog2(CAPACITY);
  localparam int CW        = $clog2(CAPACITY + 1);
  localparam int PW        = AW + 2;
  localparam int TAG_SLOTS = 2 ** TAG_W;
  // Only tags that fit the run field can ever be counted.
  localparam int RUN_SLOTS = (RUNS < TAG_SLOTS) ? RUNS : TAG_SLOTS;
  localparam int RIW       = $clog2(RUN_SLOTS);

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_POP_RD1 = 4'd3;
  localparam logic [3:0] S_POP_RD2 = 4'd4;
  localparam logic [3:0] S_DN_RDL  = 4'd5;
  localparam logic [3:0] S_DN_RDR  = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]    state;
  logic [CW-1:0] count;       // entries held
  logic [AW-1:0] pos;         // current hole position
  entry_t        cur;         // entry looking for its place
  entry_t        best;        // winner of the left child against cur during sift-down
  logic          best_left;   // best came from the left child
  logic [CW-1:0] run_buf [RUN_SLOTS];

  // Staged result word, handed to the output register in S_DONE.
  logic [STATUS_W-1:0] res_status;
  logic [KEY_W-1:0]    res_value;
  logic [TAG_W-1:0]    res_run;
  logic                res_drained;

  // Heap memory.
  entry_t        mem [CAPACITY];
  entry_t        rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // Input word fields.
  logic [KEY_W-1:0] in_value;
  logic [TAG_W-1:0] in_run;
  logic             in_accept;

  assign in_value  = s_tdata[KEY_W-1:0];
  assign in_run    = s_tdata[KEY_W +: TAG_W];
  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // Neighbor addresses of the hole.
  logic [AW-1:0] parent;
  logic [PW-1:0] left;
  logic [PW-1:0] right;
  logic          left_in;
  logic          right_in;

  assign parent   = (pos - AW'(1)) >> 1;
  assign left     = {1'b0, pos, 1'b1};
  assign right    = left + PW'(1);
  assign left_in  = (left < PW'(count));
  assign right_in = (right < PW'(count));

  // The one shared comparator.
  entry_t cmp_a;
  entry_t cmp_b;
  logic   cmp_lt;

  always_comb begin
    cmp_a = rd_data;
    cmp_b = cur;
    case (state)
      S_UP_CMP: begin
        cmp_a = cur;
        cmp_b = rd_data;
      end
      S_DN_CMP: begin
        cmp_b = best;
      end
      default: begin
        cmp_a = rd_data;
        cmp_b = cur;
      end
    endcase
  end

  assign cmp_lt = entry_before(cmp_a, cmp_b);

  // Memory port control.
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    case (state)
      S_POP_RD1: begin
        rd_addr = count[AW-1:0];
      end
      S_UP_RD: begin
        rd_addr = parent;
        wr_en   = (pos == '0);
      end
      S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = cmp_lt ? rd_data : cur;
      end
      S_DN_RDL: begin
        rd_addr = left[AW-1:0];
        wr_en   = !left_in;
      end
      S_DN_RDR: begin
        rd_addr = right[AW-1:0];
        wr_en   = !right_in;
        wr_data = cmp_lt ? rd_data : cur;
      end
      S_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = cmp_lt ? rd_data : best;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // A tag at or above RUNS is merged but not counted.
  function automatic logic tracked(logic [TAG_W-1:0] tag);
    return (32'(tag) < RUNS);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < RUN_SLOTS; i++) begin
        run_buf[i] <= '0;
      end
    end else begin
      // The output register empties when taken, unless a new word is loaded in S_DONE.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            res_value   <= '0;
            res_run     <= '0;
            res_drained <= 1'b0;
            if (s_tuser == OP_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                cur.key    <= in_value;
                cur.tag    <= in_run;
                pos        <= count[AW-1:0];
                count      <= count + CW'(1);
                if (tracked(in_run)) begin
                  run_buf[in_run[RIW-1:0]] <= run_buf[in_run[RIW-1:0]] + CW'(1);
                end
                state <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                count      <= count - CW'(1);
                state      <= S_POP_RD1;
              end
            end
          end
        end
        S_POP_RD1: begin
          // Root arrives now; it is the popped entry.
          res_value <= rd_data.key;
          res_run   <= rd_data.tag;
          if (tracked(rd_data.tag)) begin
            res_drained <= (run_buf[rd_data.tag[RIW-1:0]] <= CW'(1));
            if (run_buf[rd_data.tag[RIW-1:0]] != '0) begin
              run_buf[rd_data.tag[RIW-1:0]] <= run_buf[rd_data.tag[RIW-1:0]] - CW'(1);
            end
          end
          state <= S_POP_RD2;
        end
        S_POP_RD2: begin
          // Last entry arrives and sinks from the root.
          cur   <= rd_data;
          pos   <= '0;
          state <= (count == '0) ? S_DONE : S_DN_RDL;
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (cmp_lt) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_RDL: begin
          state <= left_in ? S_DN_RDR : S_DONE;
        end
        S_DN_RDR: begin
          if (right_in) begin
            best      <= cmp_lt ? rd_data : cur;
            best_left <= cmp_lt;
            state     <= S_DN_CMP;
          end else if (cmp_lt) begin
            pos   <= left[AW-1:0];
            state <= S_DN_RDL;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_CMP: begin
          if (cmp_lt) begin
            pos   <= right[AW-1:0];
            state <= S_DN_RDL;
          end else if (best_left) begin
            pos   <= left[AW-1:0];
            state <= S_DN_RDL;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {2'b00, (count == '0), res_drained, res_run, res_value};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("heap count above capacity");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[KEY_W-1:0] == '0) && !m_tdata[68])
    else $error("error result carries a value");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("heap memory written while idle");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (s_tuser == OP_INSERT) && (count < CW'(CAPACITY)))
      |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the heap");
`endif

endmodule

// File: test/kway_merge_heap_top_tb.sv
// Self-checking testbench for kway_merge_heap_top: a stream driver, a result monitor and an
// in-bench heap predictor that computes every expected result word from the accepted words.
// Depends on kmh_pkg and kway_merge_heap_top.
module kway_merge_heap_top_tb
  import kmh_pkg::*;
();

  localparam int ITEMS       = 1750;
  localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_WAIT  = 64;    // wait after the last result before the final check

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             wait_idle;  // hold this word back until every result is in
  } stim_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [TAG_W-1:0]    tag;
    logic                drained;
    logic                empty;
  } heap_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                s_tuser = OP_INSERT;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  kway_merge_heap_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Words waiting to be offered, and results predicted but not yet seen.
  stim_word_t   stim_q[$];
  heap_result_t awaited_results[$];

  // Word counters move with nonblocking updates so that every process reads the
  // values from before the edge.
  int words_in    = 0;
  int words_out   = 0;
  int total_words = 0;
  int mismatches  = 0;
  int quiet       = 0;
  int hold_left   = 0;
  bit held_once   = 1'b0;
  int gen_fill    = 0;  // occupancy seen by the stimulus generator, used to steer phases

  // Predictor state: a plain array heap plus per-run buffered counts.
  entry_t heap_mem [DEF_CAPACITY];
  int     heap_fill = 0;
  int     run_held [DEF_RUNS];

  initial begin
    for (int i = 0; i < DEF_RUNS; i++) run_held[i] = 0;
  end

  // One step of the merge heap. A packed entry compares as {key, tag}, which is exactly
  // the heap order: smaller key first, equal keys by lower run tag.
  function automatic heap_result_t heap_predict(logic op, logic [KEY_W-1:0] in_key,
                                                logic [TAG_W-1:0] in_tag);
    heap_result_t r;
    entry_t       tmp;
    int           pos;
    int           parent;
    int           kid;
    int           best;
    bit           done;
    r = '0;
    if (op == OP_INSERT) begin
      if (heap_fill >= DEF_CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = heap_fill;
        heap_mem[pos].key = in_key;
        heap_mem[pos].tag = in_tag;
        heap_fill++;
        done = 1'b0;
        while (pos > 0 && !done) begin
          parent = (pos - 1) / 2;
          if (heap_mem[pos] < heap_mem[parent]) begin
            tmp = heap_mem[pos];
            heap_mem[pos] = heap_mem[parent];
            heap_mem[parent] = tmp;
            pos = parent;
          end else begin
            done = 1'b1;
          end
        end
        if (int'(in_tag) < DEF_RUNS) run_held[in_tag]++;
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_OK;
        r.key = heap_mem[0].key;
        r.tag = heap_mem[0].tag;
        heap_fill--;
        if (heap_fill > 0) begin
          // Move the last entry to the root and let it sink.
          heap_mem[0] = heap_mem[heap_fill];
          pos = 0;
          done = 1'b0;
          while (!done) begin
            kid = 2 * pos + 1;
            best = pos;
            if (kid < heap_fill && heap_mem[kid] < heap_mem[best]) best = kid;
            if (kid + 1 < heap_fill && heap_mem[kid + 1] < heap_mem[best]) best = kid + 1;
            if (best == pos) begin
              done = 1'b1;
            end else begin
              tmp = heap_mem[pos];
              heap_mem[pos] = heap_mem[best];
              heap_mem[best] = tmp;
              pos = best;
            end
          end
        end
        if (int'(r.tag) < DEF_RUNS) begin
          if (run_held[r.tag] > 0) run_held[r.tag]--;
          if (run_held[r.tag] == 0) r.drained = 1'b1;
        end
      end
    end
    r.empty = (heap_fill == 0);
    return r;
  endfunction

  // Keys lean toward a small range so that equal keys from different runs meet often.
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: k = KEY_W'($urandom_range(0, 15));
      3:       k = ($urandom_range(0, 1) != 0) ? '1 : '0;
      4:       k = {60'hFFF_FFFF_FFFF_FFFF, 4'($urandom_range(0, 15))};
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  task automatic add_word(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, bit hold);
    stim_word_t w;
    w.op = op;
    w.key = key;
    w.tag = tag;
    w.wait_idle = hold;
    stim_q = {stim_q, w};
    if (op == OP_INSERT) begin
      if (gen_fill < DEF_CAPACITY) gen_fill++;
    end else if (gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  task automatic add_random(int insert_pct, bit hold);
    if ($urandom_range(0, 99) < insert_pct) begin
      add_word(OP_INSERT, rand_key(), TAG_W'($urandom_range(0, 15)), hold);
    end else begin
      // Key and tag are don't-care on a pop; drive random bits anyway.
      add_word(OP_POP, {$urandom, $urandom}, TAG_W'($urandom), hold);
    end
  endtask

  // Sender: offers the queued words, idles at random outside a steady stretch, and holds
  // back a marked word until the block has returned every result it owes.
  always @(posedge clk) begin : drive_words
    stim_word_t   nxt;
    heap_result_t pred;
    bit           go;
    bit           took;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      took = s_tvalid && s_tready;
      if (took) begin
        pred = heap_predict(s_tuser, s_tdata[KEY_W-1:0], s_tdata[KEY_W+TAG_W-1:KEY_W]);
        awaited_results = {awaited_results, pred};
        words_in <= words_in + 1;
      end
      if (!s_tvalid || took) begin
        go = (stim_q.size() > 0);
        if (go && stim_q[0].wait_idle && words_out != words_in + int'(took)) go = 1'b0;
        if (go && !(words_in >= 1100 && words_in < 1400) && $urandom_range(0, 99) < 11)
          go = 1'b0;
        if (go) begin
          nxt = stim_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.op;
          s_tdata  <= {{(IN_W-KEY_W-TAG_W){1'b0}}, nxt.tag, nxt.key};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, heap_result_t want, heap_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at result word %0d", what, words_out);
      $display("  expected status %0d value %h run %0d drained %b empty %b",
               want.status, want.key, want.tag, want.drained, want.empty);
      $display("  actual   status %0d value %h run %0d drained %b empty %b",
               got.status, got.key, got.tag, got.drained, got.empty);
    end
  endtask

  // Receiver: checks each result word against the oldest prediction. It idles at random,
  // runs a steady stretch, and once holds off long enough that the block backs up and
  // stops taking input.
  always @(posedge clk) begin : watch_results
    heap_result_t got;
    heap_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status  = m_tuser;
        got.key     = m_tdata[KEY_W-1:0];
        got.tag     = m_tdata[KEY_W+TAG_W-1:KEY_W];
        got.drained = m_tdata[KEY_W+TAG_W];
        got.empty   = m_tdata[KEY_W+TAG_W+1];
        words_out <= words_out + 1;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) report_mismatch("mismatch", want, got);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (!held_once && words_out == 400) begin
        held_once <= 1'b1;
        hold_left <= 300;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (words_out >= 1100 && words_out < 1400) || $urandom_range(0, 99) >= 11;
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : run_test
    int insert_pct;
    int chunk;

    // Directed words: pop on an empty heap, key extremes, alternating key bits, and a
    // tie on one key across runs with one run holding two entries. Popping everything
    // back shows tie order and when a run drains, and the last pop hits an empty heap.
    add_word(OP_POP,    '0,                    4'd0,  1'b0);
    add_word(OP_INSERT, '0,                    4'd0,  1'b0);
    add_word(OP_INSERT, '1,                    4'd15, 1'b0);
    add_word(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd10, 1'b0);
    add_word(OP_INSERT, 64'h5555_5555_5555_5555, 4'd5,  1'b0);
    add_word(OP_INSERT, 64'd7,                 4'd9,  1'b0);
    add_word(OP_INSERT, 64'd7,                 4'd3,  1'b0);
    add_word(OP_INSERT, 64'd7,                 4'd12, 1'b0);
    add_word(OP_INSERT, 64'd7,                 4'd3,  1'b0);
    for (int i = 0; i < 9; i++) add_word(OP_POP, '1, 4'd15, 1'b0);

    // Fill to capacity with a few pops mixed in, then push against a full heap.
    add_random(90, 1'b1);
    while (gen_fill < DEF_CAPACITY) add_random(90, 1'b0);
    for (int i = 0; i < 3; i++) add_word(OP_INSERT, rand_key(), TAG_W'($urandom), 1'b0);

    // Drain to empty, then pop a couple of times past the bottom.
    add_random(10, 1'b1);
    while (gen_fill > 0) add_random(10, 1'b0);
    for (int i = 0; i < 2; i++) add_word(OP_POP, rand_key(), TAG_W'($urandom), 1'b0);

    // Mixed traffic in chunks, each with its own insert/pop balance.
    while (stim_q.size() < ITEMS) begin
      insert_pct = $urandom_range(25, 75);
      chunk = ITEMS - stim_q.size();
      if (chunk > 100) chunk = 100;
      for (int i = 0; i < chunk; i++) add_random(insert_pct, ($urandom_range(0, 99) == 0));
    end
    total_words = stim_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (words_in != total_words || words_out != words_in) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
